// File: design/vec3_double_exp_smoother_macros.svh
// assertion macros for the vec3 double exponential smoother
// no dependencies; included by vdes_ctrl, which checks its own logic
`ifndef VEC3_DOUBLE_EXP_SMOOTHER_MACROS_SVH
`define VEC3_DOUBLE_EXP_SMOOTHER_MACROS_SVH
`ifndef SYNTHESIS
`define VDES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define VDES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VDES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define VDES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/vdes_pkg.sv
// shared types, widths and codes of the vec3 double exponential smoother
// no dependencies
package vdes_pkg;

  localparam int VAL_W         = 32;
  localparam int RATE_W        = 24;
  localparam int DT_W          = 20;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROOT_STEPS    = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic {
    REG_LEVEL_RATE = 1'b0,
    REG_TREND_RATE = 1'b1
  } reg_sel_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_FORCE, OP_GAIN, OP_P1, OP_P2, OP_T1, OP_T2, OP_LVL,
    OP_SQ1, OP_SQ2, OP_RINIT, OP_ROOT, OP_DINIT, OP_DIV, OP_DDONE, OP_CLR, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic command;
    logic make_unit;
    logic len_zero;
  } dp_stat_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[VAL_W-1:0];
  endfunction

endpackage

// File: design/vdes_if.sv
// item channels of the smoother: input items and result items
// depends on vdes_pkg
interface vdes_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [vdes_pkg::VAL_W-1:0]  sample_x;
  logic [vdes_pkg::VAL_W-1:0]  sample_y;
  logic [vdes_pkg::VAL_W-1:0]  sample_z;
  logic [vdes_pkg::DT_W-1:0]   step_time;
  logic                        make_unit;
  modport source (output valid, command, sample_x, sample_y, sample_z, step_time, make_unit,
                  input ready);
  modport sink (input valid, command, sample_x, sample_y, sample_z, step_time, make_unit,
                output ready);
endinterface

interface vdes_out_if;
  logic                        valid;
  logic                        ready;
  logic [vdes_pkg::VAL_W-1:0]  level_x;
  logic [vdes_pkg::VAL_W-1:0]  level_y;
  logic [vdes_pkg::VAL_W-1:0]  level_z;
  modport source (output valid, level_x, level_y, level_z, input ready);
  modport sink (input valid, level_x, level_y, level_z, output ready);
endinterface

// File: design/vdes_ctrl.sv
// controller of the smoother: sequences gains, axis updates, root and division
// depends on vdes_pkg and the assertion macros
`include "vec3_double_exp_smoother_macros.svh"
module vdes_ctrl #(
  parameter int FRAC_BITS = vdes_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output vdes_pkg::dp_cmd_t  cmd,
  input  vdes_pkg::dp_stat_t stat
);
  import vdes_pkg::*;

  localparam int DIV_W = VAL_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(DIV_W > ROOT_STEPS ? DIV_W : ROOT_STEPS);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_DISP  = 18'h00002,
    S_FORCE = 18'h00004,
    S_GAIN  = 18'h00008,
    S_P1    = 18'h00010,
    S_P2    = 18'h00020,
    S_T1    = 18'h00040,
    S_T2    = 18'h00080,
    S_LVL   = 18'h00100,
    S_SQ1   = 18'h00200,
    S_SQ2   = 18'h00400,
    S_RINIT = 18'h00800,
    S_ROOT  = 18'h01000,
    S_DINIT = 18'h02000,
    S_DIV   = 18'h04000,
    S_DDONE = 18'h08000,
    S_CLR   = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    cmd.op        = OP_NONE;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        axis_nxt  = 2'd0;
        state_nxt = stat.command ? S_FORCE : S_GAIN;
      end
      S_FORCE: begin
        cmd.op    = OP_FORCE;
        state_nxt = S_OUT;
      end
      S_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = S_P1;
      end
      S_P1: begin
        cmd.op    = OP_P1;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.op    = OP_P2;
        state_nxt = S_T1;
      end
      S_T1: begin
        cmd.op    = OP_T1;
        state_nxt = S_T2;
      end
      S_T2: begin
        cmd.op    = OP_T2;
        state_nxt = S_LVL;
      end
      S_LVL: begin
        cmd.op = OP_LVL;
        if (axis_r == 2'd2) begin
          axis_nxt  = 2'd0;
          state_nxt = stat.make_unit ? S_SQ1 : S_OUT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_P1;
        end
      end
      S_SQ1: begin
        cmd.op    = OP_SQ1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.op = OP_SQ2;
        if (axis_r == 2'd2) begin
          axis_nxt  = 2'd0;
          state_nxt = S_RINIT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_SQ1;
        end
      end
      S_RINIT: begin
        cmd.op    = OP_RINIT;
        cnt_nxt   = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.op  = OP_ROOT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.op  = OP_DINIT;
        cnt_nxt = '0;
        state_nxt = stat.len_zero ? S_CLR : S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) state_nxt = S_DDONE;
      end
      S_DDONE: begin
        cmd.op = OP_DDONE;
        if (axis_r == 2'd2) begin
          state_nxt = S_CLR;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_DINIT;
        end
      end
      S_CLR: begin
        cmd.op    = OP_CLR;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.op        = OP_PUSH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 2'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `VDES_ASSERT_NXT(a_accept_disp, clk, rst_n, in_valid && state_r == S_IDLE, state_r == S_DISP, "accepted item not dispatched")
  `VDES_ASSERT_NXT(a_root_holds, clk, rst_n, state_r == S_ROOT && cnt_r != CNT_W'(ROOT_STEPS - 1), state_r == S_ROOT, "root left early")
  `VDES_ASSERT_NXT(a_out_from_push, clk, rst_n, !out_valid_r && state_r != S_OUT, !out_valid_r, "result without push")

endmodule

// File: design/vdes_dp.sv
// datapath of the smoother: state vectors, gains, axis updates, root and divider
// depends on vdes_pkg
module vdes_dp #(
  parameter int FRAC_BITS = vdes_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vdes_pkg::dp_cmd_t            cmd,
  output vdes_pkg::dp_stat_t           stat,
  input  logic                         in_command,
  input  logic [vdes_pkg::VAL_W-1:0]   in_sample_x,
  input  logic [vdes_pkg::VAL_W-1:0]   in_sample_y,
  input  logic [vdes_pkg::VAL_W-1:0]   in_sample_z,
  input  logic [vdes_pkg::DT_W-1:0]    in_step_time,
  input  logic                         in_make_unit,
  input  logic [vdes_pkg::RATE_W-1:0]  level_rate,
  input  logic [vdes_pkg::RATE_W-1:0]  trend_rate,
  output logic [vdes_pkg::VAL_W-1:0]   out_level_x,
  output logic [vdes_pkg::VAL_W-1:0]   out_level_y,
  output logic [vdes_pkg::VAL_W-1:0]   out_level_z
);
  import vdes_pkg::*;

  localparam int GPW   = RATE_W + DT_W;
  localparam int PW    = FRAC_BITS + 36;
  localparam int DIV_W = VAL_W + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [VAL_W-1:0] level_r [3];
  logic signed [VAL_W-1:0] prior_r [3];
  logic signed [VAL_W-1:0] trend_r [3];
  logic signed [VAL_W-1:0] sample_r [3];
  logic signed [VAL_W-1:0] old_r;
  logic [DT_W-1:0]         dt_r;
  logic                    cmd_r;
  logic                    mk_r;
  logic [FRAC_BITS:0]      ga_r, gb_r;
  logic signed [PW-1:0]    prod_r;
  logic [63:0]             sq_r, acc_r, s_r, res_r, bit_r;
  logic [DIV_W-1:0]        num_r, q_r;
  logic [VAL_W:0]          rem_r;
  logic [VAL_W-1:0]        out_x_r, out_y_r, out_z_r;

  logic signed [VAL_W-1:0] lv, pr, tr, smp;
  logic [VAL_W-1:0]        mag, len;
  logic signed [33:0]      diff_a, diff_t, dsel;
  logic [FRAC_BITS:0]      gsel, ga_nxt, gb_nxt;
  logic [GPW-1:0]          pa, pb;
  logic signed [PW-1:0]    prod_nxt, rs;
  logic signed [VAL_W-1:0] upd_sat, lvl_sat, div_sat;
  logic [63:0]             root_try;
  logic [VAL_W:0]          rem_sh;
  logic                    rem_ge;
  logic signed [63:0]      q_signed;

  assign lv  = level_r[cmd.axis];
  assign pr  = prior_r[cmd.axis];
  assign tr  = trend_r[cmd.axis];
  assign smp = sample_r[cmd.axis];
  assign mag = lv[VAL_W-1] ? (~lv + 1'b1) : lv;
  assign len = res_r[VAL_W-1:0];

  assign diff_a   = 34'(smp) - 34'(lv);
  assign diff_t   = (34'(pr) - 34'(old_r)) - 34'(tr);
  assign gsel     = (cmd.op == OP_P1) ? ga_r : gb_r;
  assign dsel     = (cmd.op == OP_P1) ? diff_a : diff_t;
  assign prod_nxt = $signed({1'b0, gsel}) * dsel;
  assign rs       = (prod_r + HALF) >>> FRAC_BITS;
  assign upd_sat  = sat32(64'(rs) + 64'((cmd.op == OP_P2) ? lv : tr));
  assign lvl_sat  = sat32(64'(tr) + 64'(pr));

  assign pa     = (GPW'(level_rate) * GPW'(dt_r)) >> FRAC_BITS;
  assign pb     = (GPW'(trend_rate) * GPW'(dt_r)) >> FRAC_BITS;
  assign ga_nxt = (pa > GPW'(ONE)) ? ONE : pa[FRAC_BITS:0];
  assign gb_nxt = (pb > GPW'(ONE)) ? ONE : pb[FRAC_BITS:0];

  assign root_try = res_r + bit_r;
  assign rem_sh   = {rem_r[VAL_W-1:0], num_r[DIV_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, len};
  assign q_signed = lv[VAL_W-1] ? -$signed(64'(q_r)) : $signed(64'(q_r));
  assign div_sat  = sat32(q_signed);

  assign stat.command   = cmd_r;
  assign stat.make_unit = mk_r;
  assign stat.len_zero  = (len == '0);

  assign out_level_x = out_x_r;
  assign out_level_y = out_y_r;
  assign out_level_z = out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        level_r[i] <= '0;
        prior_r[i] <= '0;
        trend_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_FORCE: begin
          for (int i = 0; i < 3; i++) begin
            level_r[i] <= sample_r[i];
            prior_r[i] <= sample_r[i];
            trend_r[i] <= '0;
          end
        end
        OP_P2:    prior_r[cmd.axis] <= upd_sat;
        OP_T2:    trend_r[cmd.axis] <= upd_sat;
        OP_LVL:   level_r[cmd.axis] <= lvl_sat;
        OP_DDONE: level_r[cmd.axis] <= div_sat;
        OP_CLR: begin
          for (int i = 0; i < 3; i++) trend_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        sample_r[0] <= in_sample_x;
        sample_r[1] <= in_sample_y;
        sample_r[2] <= in_sample_z;
        dt_r        <= in_step_time;
        cmd_r       <= in_command;
        mk_r        <= in_make_unit;
      end
      OP_GAIN: begin
        ga_r <= ga_nxt;
        gb_r <= gb_nxt;
      end
      OP_P1: begin
        prod_r <= prod_nxt;
        old_r  <= pr;
      end
      OP_T1: prod_r <= prod_nxt;
      OP_SQ1: sq_r <= 64'(mag) * 64'(mag);
      OP_SQ2: acc_r <= ((cmd.axis == 2'd0) ? 64'd0 : acc_r) + sq_r;
      OP_RINIT: begin
        s_r   <= acc_r;
        res_r <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
      end
      OP_ROOT: begin
        if (s_r >= root_try) begin
          s_r   <= s_r - root_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DINIT: begin
        num_r <= (DIV_W'(mag) << FRAC_BITS) + DIV_W'(len >> 1);
        rem_r <= '0;
        q_r   <= '0;
      end
      OP_DIV: begin
        rem_r <= rem_ge ? (rem_sh - {1'b0, len}) : rem_sh;
        q_r   <= {q_r[DIV_W-2:0], rem_ge};
        num_r <= num_r << 1;
      end
      OP_PUSH: begin
        out_x_r <= level_r[0];
        out_y_r <= level_r[1];
        out_z_r <= level_r[2];
      end
      default: ;
    endcase
  end

endmodule

// File: design/vec3_double_exp_smoother.sv
// Three-axis Holt double exponential smoother on Q16.16 vectors. Every input item gives one
// result item holding the level vector after it. A smooth item runs a gain stage, then five
// steps per axis through one gain multiplier; with make_unit set, the squares, the 32-step
// square root and the bit-serial divider that scales each axis follow. One item is in work
// at a time; a finished result waits in the output register while the next item is taken.
// Rates are written through the APB port at 0x0, 0x4.
module vec3_double_exp_smoother #(
  parameter int FRAC_BITS = vdes_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  vdes_in_if.sink                           in_ch,
  vdes_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [vdes_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [vdes_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [vdes_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import vdes_pkg::*;

  logic [RATE_W-1:0] level_rate_r, trend_rate_r;
  logic              cfg_wr;
  reg_sel_t          cfg_sel;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = reg_sel_t'(cfg_paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      REG_LEVEL_RATE: cfg_prdata = CFG_DATA_W'(level_rate_r);
      REG_TREND_RATE: cfg_prdata = CFG_DATA_W'(trend_rate_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_rate_r <= '0;
      trend_rate_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LEVEL_RATE: level_rate_r <= cfg_pwdata[RATE_W-1:0];
        REG_TREND_RATE: trend_rate_r <= cfg_pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  vdes_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  vdes_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_command   (in_ch.command),
    .in_sample_x  (in_ch.sample_x),
    .in_sample_y  (in_ch.sample_y),
    .in_sample_z  (in_ch.sample_z),
    .in_step_time (in_ch.step_time),
    .in_make_unit (in_ch.make_unit),
    .level_rate   (level_rate_r),
    .trend_rate   (trend_rate_r),
    .out_level_x  (out_ch.level_x),
    .out_level_y  (out_ch.level_y),
    .out_level_z  (out_ch.level_z)
  );

endmodule

// File: verif/vdes_scoreboard.sv
`timescale 1ns / 1ps
// scoreboard for the vec3 double exponential smoother: predicts the level vector of every
// accepted item and compares it with the result channel; depends on vdes_pkg and vdes_if
module vdes_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  vdes_in_if                              in_mon,
  vdes_out_if                             out_mon,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic                            cfg_pready,
  input  logic [vdes_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [vdes_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                              errors,
  output int                              pending
);
  import vdes_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } level_vec_t;

  level_vec_t              level_q[$];
  logic [RATE_W-1:0]       lvl_rate;
  logic [RATE_W-1:0]       trd_rate;
  logic signed [31:0]      lvl[3];
  logic signed [31:0]      prior[3];
  logic signed [31:0]      trd[3];

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint round_q(input longint v);
    return (v + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint gain_of(input logic [RATE_W-1:0] rate, input logic [DT_W-1:0] dt);
    longint unsigned g;
    g = (longint'(rate) * longint'(dt)) >> FB;
    return (g > (64'd1 << FB)) ? (64'sd1 <<< FB) : longint'(g);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic advance_level(input logic cmd, input longint smp[3],
                               input logic [DT_W-1:0] dt, input logic unit);
    longint ga, gb, old, p, d, t, v;
    longint unsigned sq, len, m, q;
    if (cmd) begin
      for (int i = 0; i < 3; i++) begin
        lvl[i] = 32'(smp[i]);
        prior[i] = 32'(smp[i]);
        trd[i] = '0;
      end
    end else begin
      ga = gain_of(lvl_rate, dt);
      gb = gain_of(trd_rate, dt);
      for (int i = 0; i < 3; i++) begin
        old = prior[i];
        p = longint'(lvl[i]) + round_q(ga * (smp[i] - longint'(lvl[i])));
        prior[i] = clip32(p);
        d = (longint'(prior[i]) - old) - longint'(trd[i]);
        t = longint'(trd[i]) + round_q(gb * d);
        trd[i] = clip32(t);
        lvl[i] = clip32(longint'(trd[i]) + longint'(prior[i]));
      end
      if (unit) begin
        sq = 0;
        for (int i = 0; i < 3; i++) begin
          v = lvl[i];
          m = (v < 0) ? -v : v;
          sq = sq + m * m;
        end
        len = root_floor(sq);
        if (len != 0) begin
          for (int i = 0; i < 3; i++) begin
            v = lvl[i];
            m = (v < 0) ? -v : v;
            q = ((m << FB) + (len >> 1)) / len;
            lvl[i] = clip32((v < 0) ? -longint'(q) : longint'(q));
          end
        end
        for (int i = 0; i < 3; i++) trd[i] = '0;
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    $display("mismatch at %0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    longint smp[3];
    level_vec_t e;
    if (!rst_n) begin
      lvl_rate = '0;
      trd_rate = '0;
      for (int i = 0; i < 3; i++) begin
        lvl[i] = '0;
        prior[i] = '0;
        trd[i] = '0;
      end
      level_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == {REG_LEVEL_RATE, 2'b00}) lvl_rate = cfg_pwdata[RATE_W-1:0];
        else if (cfg_paddr == {REG_TREND_RATE, 2'b00}) trd_rate = cfg_pwdata[RATE_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (level_q.size() == 0) begin
          report("unexpected item x", 32'hx, out_mon.level_x);
        end else begin
          e = level_q.pop_front();
          if (out_mon.level_x !== e.x) report("level_x", e.x, out_mon.level_x);
          if (out_mon.level_y !== e.y) report("level_y", e.y, out_mon.level_y);
          if (out_mon.level_z !== e.z) report("level_z", e.z, out_mon.level_z);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        smp[0] = longint'($signed(in_mon.sample_x));
        smp[1] = longint'($signed(in_mon.sample_y));
        smp[2] = longint'($signed(in_mon.sample_z));
        advance_level(in_mon.command, smp, in_mon.step_time, in_mon.make_unit);
        e.x = lvl[0];
        e.y = lvl[1];
        e.z = lvl[2];
        level_q.push_back(e);
      end
      pending = level_q.size();
    end
  end

endmodule

// File: verif/tb_vec3_double_exp_smoother.sv
`timescale 1ns / 1ps
// top of the smoother testbench: clock, reset, rate writes and item stimulus
// depends on vdes_pkg, vdes_if, the smoother and vdes_scoreboard
module tb_vec3_double_exp_smoother;
  import vdes_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    errors;
  int                    pending;
  int                    in_idle;
  int                    out_idle;
  logic                  hold_go;
  logic                  hold_start;

  vdes_in_if  in_bus ();
  vdes_out_if out_bus ();

  vec3_double_exp_smoother dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  vdes_scoreboard sb (
    .clk(clk), .rst_n(rst_n), .in_mon(in_bus), .out_mon(out_bus),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= !hold_go && ($urandom_range(99) >= out_idle);
  end

  initial begin
    hold_go = 1'b0;
    forever begin
      @(posedge hold_start);
      hold_go = 1'b1;
      repeat (400) @(posedge clk);
      hold_go = 1'b0;
    end
  end

  task automatic write_rate(input reg_sel_t sel, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic send(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] z, input logic [DT_W-1:0] dt, input logic unit);
    if ($urandom_range(99) < in_idle) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.sample_x  <= x;
    in_bus.sample_y  <= y;
    in_bus.sample_z  <= z;
    in_bus.step_time <= dt;
    in_bus.make_unit <= unit;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      2: return DT_W'($urandom);
      default: return DT_W'($urandom_range(0, 32'h0001_0000));
    endcase
  endfunction

  task automatic random_items(input int count);
    logic cmd;
    for (int k = 0; k < count; k++) begin
      cmd = ($urandom_range(99) < 10);
      send(cmd, pick_value(), pick_value(), pick_value(), pick_dt(),
           $urandom_range(99) < 15);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    hold_start  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_bus.valid     = 1'b0;
    in_bus.command   = 1'b0;
    in_bus.sample_x  = '0;
    in_bus.sample_y  = '0;
    in_bus.sample_z  = '0;
    in_bus.step_time = '0;
    in_bus.make_unit = 1'b0;
    in_idle  = 8;
    out_idle = 77;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero rates: gains stay zero
    write_rate(REG_LEVEL_RATE, 32'h0);
    write_rate(REG_TREND_RATE, 32'hFF00_0000);
    send(1'b0, 32'h0001_0000, 32'h0, 32'h0, '1, 1'b1);
    send(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, '1, 1'b1);
    send(1'b0, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, '1, 1'b0);
    send(1'b0, 32'h0, 32'h0, 32'h0, '0, 1'b1);
    send(1'b1, 32'h0, 32'h0, 32'h0, '0, 1'b0);
    send(1'b0, 32'h0, 32'h0, 32'h0, '1, 1'b1);
    drain();

    // full rates: gains capped at one, saturation
    write_rate(REG_LEVEL_RATE, 32'hFFFF_FFFF);
    write_rate(REG_TREND_RATE, 32'h00FF_FFFF);
    send(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 1'b0);
    send(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 1'b0);
    send(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1, 1'b0);
    send(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 20'h1, 1'b1);
    send(1'b0, 32'hFFFF_0000, 32'h0003_0000, 32'h0004_0000, 20'h1_0000, 1'b1);
    send(1'b0, 32'h0, 32'h0, 32'h0, 20'h1_0000, 1'b1);
    send(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, 1'b0);
    send(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'h0_8000, 1'b1);
    send(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 20'h0_0001, 1'b1);
    random_items(280);
    drain();

    in_idle  = 77;
    out_idle = 8;
    write_rate(REG_LEVEL_RATE, 32'h0000_8000);
    write_rate(REG_TREND_RATE, 32'h0000_2000);
    random_items(200);
    in_idle = 0;
    hold_start = 1'b1;
    random_items(40);
    in_idle = 77;
    random_items(160);
    drain();

    in_idle  = 0;
    out_idle = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_rate(REG_LEVEL_RATE, $urandom);
      write_rate(REG_TREND_RATE, $urandom);
      random_items(115);
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
